/* hw/rtl/fdbc_pkg.sv */
// Package for the fan deadzone/boost conditioner.
// Holds action and register codes, fixed limits and the percent-to-PWM map.
// No dependencies.
package fdbc_pkg;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_BOOST  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_CONSTANT_AIRFLOW = 3'd0,
        REG_CLAMP_MIN        = 3'd1,
        REG_CLAMP_MAX        = 3'd2,
        REG_ON_MARGIN        = 3'd3,
        REG_MIN_OFF_TICKS    = 3'd4,
        REG_ON_HOLD_TICKS    = 3'd5,
        REG_BOOST_SECONDS    = 3'd6
    } cfg_index_t;

    localparam logic [6:0]  FULL_PERCENT     = 7'd100;
    localparam logic [7:0]  FULL_PWM         = 8'd255;
    localparam logic [15:0] TIMER16_MAX      = 16'hFFFF;
    localparam logic [19:0] BOOST_TIMER_MAX  = 20'hFFFFF;
    localparam logic [9:0]  TICKS_PER_SECOND = 10'd1000;

    // Result beat: fan_percent, pwm_duty, fan_off, boosting (low bits first)
    typedef struct packed {
        logic       boosting;
        logic       fan_off;
        logic [7:0] pwm_duty;
        logic [6:0] fan_percent;
    } result_t;

    // floor(pct*255/100) = floor(floor(pct*51/4)/5); /5 by reciprocal 13108/2^16
    function automatic logic [7:0] pct_to_pwm(input logic [6:0] pct);
        logic [12:0] x;
        logic [10:0] y;
        logic [24:0] prod;
        x    = {1'b0, pct, 5'd0} + {2'd0, pct, 4'd0} + {5'd0, pct, 1'b0} + {6'd0, pct};
        y    = x[12:2];
        prod = {14'd0, y} * 25'd13108;
        return prod[23:16];
    endfunction

endpackage

/* hw/rtl/fdbc_skid.sv */
// Two-entry output buffer (output register plus skid register) for result beats.
// Depends on fdbc_pkg for result_t.
module fdbc_skid
    import fdbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    drain;

    assign drain = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
        end
        else if (!out_valid_reg || drain)
        begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full     = skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_data   = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !drain) |-> !push)
        else $error("beat pushed into full buffer");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled output beat changed");

endmodule

/* hw/rtl/fan_deadzone_boost_conditioner.sv */
// Fan demand conditioner: boost override, clamp or deadzone with min-off time.
// A sample's result is written into the output buffer when its input beat is taken.
// Throughput: one input beat per cycle while s_tready is high; ticks and boost starts give no result beat.
// A two-entry output buffer keeps input flowing while a result waits; s_tready drops
// only when both entries are full. rst_n (async, low) clears timers, flags and
// registers to their defaults; the output buffer comes up empty.
module fan_deadzone_boost_conditioner
    import fdbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] raw_percent, [7] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [6:0] fan_percent, [14:7] pwm_duty, [15] fan_off,
                                   // [16] boosting, [23:17] zero
);

    // configuration
    logic        constant_airflow_reg;
    logic [6:0]  clamp_min_reg;
    logic [6:0]  clamp_max_reg;
    logic [6:0]  on_margin_reg;
    logic [15:0] min_off_ticks_reg;
    logic [15:0] on_hold_ticks_reg;
    logic [19:0] boost_limit_reg;

    // state
    logic        held_off_reg, held_off_next;
    logic [15:0] off_elapsed_reg, off_elapsed_next;
    logic        restart_pending_reg, restart_pending_next;
    logic [15:0] restart_elapsed_reg, restart_elapsed_next;
    logic        boost_active_reg, boost_active_next;
    logic [19:0] boost_elapsed_reg, boost_elapsed_next;

    logic        accept;
    action_t     act;
    logic [6:0]  raw_sat;
    logic [6:0]  clamped;
    logic [6:0]  pct;
    logic [7:0]  on_level;
    logic        boost_hit;
    logic        res_valid;
    result_t     res;
    result_t     out_beat;
    logic        buf_full;
    logic [19:0] boost_cnt;
    logic [19:0] limit_calc;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !buf_full;
    assign act      = action_t'(s_tuser);
    assign raw_sat  = (s_tdata[6:0] > FULL_PERCENT) ? FULL_PERCENT : s_tdata[6:0];
    assign on_level = {1'b0, clamp_min_reg} + {1'b0, on_margin_reg};
    assign boost_hit = boost_active_reg && (boost_elapsed_reg >= boost_limit_reg);
    assign limit_calc = {10'd0, cfg_wdata[9:0]} * {10'd0, TICKS_PER_SECOND};

    always_comb
    begin
        clamped = (raw_sat < clamp_min_reg) ? clamp_min_reg : raw_sat;
        if (clamped > clamp_max_reg)
            clamped = clamp_max_reg;
    end

    always_comb
    begin
        held_off_next        = held_off_reg;
        off_elapsed_next     = off_elapsed_reg;
        restart_pending_next = restart_pending_reg;
        restart_elapsed_next = restart_elapsed_reg;
        boost_active_next    = boost_active_reg;
        boost_elapsed_next   = boost_elapsed_reg;
        boost_cnt            = boost_elapsed_reg;
        res_valid            = 1'b0;
        pct                  = 7'd0;
        res.fan_off          = 1'b0;
        res.boosting         = 1'b0;
        res.pwm_duty         = 8'd0;
        case (act)
            ACT_TICK:
            begin
                if (held_off_reg && off_elapsed_reg != TIMER16_MAX)
                    off_elapsed_next = off_elapsed_reg + 16'd1;
                if (restart_pending_reg && restart_elapsed_reg != TIMER16_MAX)
                    restart_elapsed_next = restart_elapsed_reg + 16'd1;
                if (boost_active_reg && boost_elapsed_reg != BOOST_TIMER_MAX)
                    boost_cnt = boost_elapsed_reg + 20'd1;
                boost_elapsed_next = boost_cnt;
                if (boost_active_reg && boost_cnt >= boost_limit_reg)
                    boost_active_next = 1'b0;
            end
            ACT_BOOST:
            begin
                boost_active_next  = 1'b1;
                boost_elapsed_next = 20'd0;
            end
            ACT_SAMPLE:
            begin
                res_valid = 1'b1;
                if (boost_active_reg && !boost_hit)
                begin
                    pct          = FULL_PERCENT;
                    res.boosting = 1'b1;
                end
                else
                begin
                    boost_active_next = 1'b0;
                    if (constant_airflow_reg)
                    begin
                        pct = clamped;
                    end
                    else if (held_off_reg)
                    begin
                        res.fan_off = 1'b1;
                        if (off_elapsed_reg < min_off_ticks_reg)
                        begin
                            restart_pending_next = 1'b0;
                        end
                        else if ({1'b0, raw_sat} >= on_level)
                        begin
                            if (!restart_pending_reg)
                            begin
                                restart_pending_next = 1'b1;
                                restart_elapsed_next = 16'd0;
                            end
                            // a fresh qualify window starts at zero
                            if ((restart_pending_reg ? restart_elapsed_reg : 16'd0)
                                >= on_hold_ticks_reg)
                            begin
                                pct                  = clamp_min_reg;
                                res.fan_off          = 1'b0;
                                held_off_next        = 1'b0;
                                restart_pending_next = 1'b0;
                            end
                        end
                        else
                        begin
                            restart_pending_next = 1'b0;
                        end
                    end
                    else if (raw_sat < clamp_min_reg)
                    begin
                        res.fan_off          = 1'b1;
                        held_off_next        = 1'b1;
                        off_elapsed_next     = 16'd0;
                        restart_pending_next = 1'b0;
                    end
                    else
                    begin
                        pct = clamped;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (pct > FULL_PERCENT)
            pct = FULL_PERCENT;
        res.fan_percent = pct;
        res.pwm_duty    = res.boosting ? FULL_PWM : pct_to_pwm(pct);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            constant_airflow_reg <= 1'b0;
            clamp_min_reg        <= 7'd20;
            clamp_max_reg        <= 7'd100;
            on_margin_reg        <= 7'd10;
            min_off_ticks_reg    <= 16'd20000;
            on_hold_ticks_reg    <= 16'd10000;
            boost_limit_reg      <= 20'd60000;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_CONSTANT_AIRFLOW: constant_airflow_reg <= cfg_wdata[0];
                REG_CLAMP_MIN:        clamp_min_reg        <= cfg_wdata[6:0];
                REG_CLAMP_MAX:        clamp_max_reg        <= cfg_wdata[6:0];
                REG_ON_MARGIN:        on_margin_reg        <= cfg_wdata[6:0];
                REG_MIN_OFF_TICKS:    min_off_ticks_reg    <= cfg_wdata;
                REG_ON_HOLD_TICKS:    on_hold_ticks_reg    <= cfg_wdata;
                REG_BOOST_SECONDS:    boost_limit_reg      <= limit_calc;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_off_reg        <= 1'b0;
            off_elapsed_reg     <= 16'd0;
            restart_pending_reg <= 1'b0;
            restart_elapsed_reg <= 16'd0;
            boost_active_reg    <= 1'b0;
            boost_elapsed_reg   <= 20'd0;
        end
        else if (accept)
        begin
            held_off_reg        <= held_off_next;
            off_elapsed_reg     <= off_elapsed_next;
            restart_pending_reg <= restart_pending_next;
            restart_elapsed_reg <= restart_elapsed_next;
            boost_active_reg    <= boost_active_next;
            boost_elapsed_reg   <= boost_elapsed_next;
        end
    end

    fdbc_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (buf_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (out_beat)
    );

    assign m_tdata = {7'd0, out_beat};

    a_pending_only_off: assert property (@(posedge clk) disable iff (!rst_n)
        restart_pending_reg |-> held_off_reg)
        else $error("restart pending while fan running");

    a_boost_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_beat.boosting) |->
            (out_beat.fan_percent == FULL_PERCENT && out_beat.pwm_duty == FULL_PWM
             && !out_beat.fan_off))
        else $error("boost beat not at full output");

    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_beat.fan_off) |-> (out_beat.fan_percent == 7'd0
            && out_beat.pwm_duty == 8'd0))
        else $error("fan off beat with nonzero demand");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_beat.fan_percent <= FULL_PERCENT))
        else $error("fan percent above full scale");

endmodule
